// ===== hdl/shbr_pkg.sv =====
// ----------------------------------------------------------------------------
// shbr_pkg: shared types and constants of the snapshot history ring
// Sizes, field widths, codes and the structs that run between the
// sequencer, the slot metadata store and the body memory.
// ----------------------------------------------------------------------------
package shbr_pkg;

    // Storage sizes.
    localparam int RING_DEPTH  = 16;
    localparam int SLOT_BODIES = 64;
    localparam int BODY_BITS   = 64;

    // Fixed field widths.
    localparam int TICK_W = 64;
    localparam int DATA_W = 64;
    localparam int CNT_W  = 7;
    localparam int RING_W = 5;

    // Derived widths.
    localparam int PTR_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int BODY_DEPTH = (RING_DEPTH + 1) * SLOT_BODIES;
    localparam int BODY_AW   = (BODY_DEPTH > 1) ? $clog2(BODY_DEPTH) : 1;
    localparam int BASE_OFF  = RING_DEPTH * SLOT_BODIES;

    // Stream widths.
    localparam int S_TDATA_W = ((TICK_W + DATA_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((TICK_W + CNT_W + 7) / 8) * 8;
    localparam int S_TUSER_W = 2;
    localparam int M_TUSER_W = 1;

    // Configuration port.
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_RING_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_LIMIT = 2'd1;

    // Item kinds and result status.
    localparam logic KIND_RECORD = 1'b0;
    localparam logic KIND_ACK    = 1'b1;
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_EXPIRED = 1'b1;

    // Effective configuration after clamping.
    typedef struct packed {
        logic [RING_W-1:0] ring;
        logic [CNT_W-1:0]  limit;
    } cfg_t;

    // Slot metadata write: tick at record start, count at record close.
    typedef struct packed {
        logic              tick_en;
        logic              count_en;
        logic [PTR_W-1:0]  idx;
        logic [TICK_W-1:0] tick;
        logic [CNT_W-1:0]  count;
    } meta_wr_t;

    typedef struct packed {
        logic             en;
        logic [PTR_W-1:0] idx;
    } meta_rd_t;

    typedef struct packed {
        logic [TICK_W-1:0] tick;
        logic [CNT_W-1:0]  count;
    } meta_q_t;

    // Body memory request, one write and one read port.
    typedef struct packed {
        logic                 we;
        logic [BODY_AW-1:0]   waddr;
        logic [BODY_BITS-1:0] wdata;
        logic                 re;
        logic [BODY_AW-1:0]   raddr;
    } body_req_t;

endpackage

// ===== hdl/snapshot_history_baseline_ring.sv =====
// ----------------------------------------------------------------------------
// snapshot_history_baseline_ring: ring of recent snapshots with acked baseline
// Records snapshots into a ring of slots and, on an acknowledge beat,
// copies the matching slot into the baseline and reports ok or expired.
// ----------------------------------------------------------------------------
// Every accepted beat yields exactly one result beat. A record beat (kind 0)
// completes in the cycle it is accepted, so record beats stream at one per
// cycle as long as the result side keeps up; the result register lets the
// next beat in while the previous result is being taken. An acknowledge beat
// (kind 1) stalls the input while it works. The search reads the slot tick
// memory once per cycle, newest filled slot first, and compares each tick
// in the cycle after its read; a miss ends once every filled slot has been
// compared, and a hit ends the search. A hit then copies its body words
// through the single read port of the body memory at one word per cycle.
// A final state posts the result once the result register is free, after
// which the input opens again. After ring_size is written the write
// pointer is folded back into the new range by repeated subtraction,
// holding s_tready low until it is back in range. Body words of all slots
// and the baseline copy share one memory: slot s owns words s*SLOT_BODIES
// and up, the baseline sits behind the last slot. Slot ticks live in a
// second memory with one valid bit per slot, so no clearing pass is needed
// after reset.
// ----------------------------------------------------------------------------
module snapshot_history_baseline_ring (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Configuration write port.
    input  logic                             cfg_we,
    input  logic [shbr_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  logic [shbr_pkg::CFG_DAT_W-1:0]   cfg_wdata,
    // Input stream.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [shbr_pkg::S_TDATA_W-1:0]   s_tdata,  // tick, body_data
    input  logic [shbr_pkg::S_TUSER_W-1:0]   s_tuser,  // kind, body_present
    input  logic                             s_tlast,
    // Result stream.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [shbr_pkg::M_TDATA_W-1:0]   m_tdata,  // base_tick, base_count
    output logic [shbr_pkg::M_TUSER_W-1:0]   m_tuser   // status
);

    logic [shbr_pkg::RING_W-1:0] ring_size_reg;
    logic [shbr_pkg::CNT_W-1:0]  slot_limit_reg;
    shbr_pkg::cfg_t              cfg;

    shbr_pkg::meta_wr_t          meta_wr;
    shbr_pkg::meta_rd_t          meta_rd;
    shbr_pkg::meta_q_t           meta_q;
    shbr_pkg::body_req_t         body_req;
    logic [shbr_pkg::BODY_BITS-1:0] body_rdata;

    logic                        out_status;
    logic [shbr_pkg::TICK_W-1:0] out_tick;
    logic [shbr_pkg::CNT_W-1:0]  out_count;

    // Configuration registers; an index beyond the list is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_size_reg  <= shbr_pkg::RING_W'(16);
            slot_limit_reg <= shbr_pkg::CNT_W'(64);
        end else if (cfg_we) begin
            unique case (cfg_idx)
                shbr_pkg::CFG_RING_SIZE:  ring_size_reg  <= cfg_wdata[shbr_pkg::RING_W-1:0];
                shbr_pkg::CFG_SLOT_LIMIT: slot_limit_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // A ring size of zero behaves as one; both registers clamp to the
    // storage that is actually built.
    always_comb begin
        if (ring_size_reg == '0) begin
            cfg.ring = shbr_pkg::RING_W'(1);
        end else if (32'(ring_size_reg) > shbr_pkg::RING_DEPTH) begin
            cfg.ring = shbr_pkg::RING_W'(shbr_pkg::RING_DEPTH);
        end else begin
            cfg.ring = ring_size_reg;
        end
        if (32'(slot_limit_reg) > shbr_pkg::SLOT_BODIES) begin
            cfg.limit = shbr_pkg::CNT_W'(shbr_pkg::SLOT_BODIES);
        end else begin
            cfg.limit = slot_limit_reg;
        end
    end

    shbr_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_kind    (s_tuser[0]),
        .in_tick    (s_tdata[shbr_pkg::TICK_W-1:0]),
        .in_body    (s_tdata[shbr_pkg::TICK_W +: shbr_pkg::DATA_W]),
        .in_present (s_tuser[1]),
        .in_last    (s_tlast),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (out_status),
        .out_tick   (out_tick),
        .out_count  (out_count),
        .meta_wr    (meta_wr),
        .meta_rd    (meta_rd),
        .meta_q     (meta_q),
        .body_req   (body_req),
        .body_rdata (body_rdata)
    );

    shbr_meta u_meta (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (meta_wr),
        .rd      (meta_rd),
        .q       (meta_q)
    );

    // Slot bodies plus the baseline region in one memory.
    shbr_ram #(
        .WIDTH (shbr_pkg::BODY_BITS),
        .DEPTH (shbr_pkg::BODY_DEPTH)
    ) u_body_ram (
        .clk   (aclk),
        .we    (body_req.we),
        .waddr (body_req.waddr),
        .wdata (body_req.wdata),
        .re    (body_req.re),
        .raddr (body_req.raddr),
        .rdata (body_rdata)
    );

    assign m_tdata = {{(shbr_pkg::M_TDATA_W - shbr_pkg::TICK_W - shbr_pkg::CNT_W){1'b0}},
                      out_count, out_tick};
    assign m_tuser = out_status;

endmodule

// ===== hdl/shbr_ram.sv =====
// ----------------------------------------------------------------------------
// shbr_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module shbr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/shbr_meta.sv =====
// ----------------------------------------------------------------------------
// shbr_meta: per-slot tick and body count store
// Ticks live in a RAM with a valid bit per slot; a slot never written
// reads as tick zero. Counts are a small reset-cleared register array.
// ----------------------------------------------------------------------------
module shbr_meta (
    input  logic              aclk,
    input  logic              aresetn,
    input  shbr_pkg::meta_wr_t wr,
    input  shbr_pkg::meta_rd_t rd,
    output shbr_pkg::meta_q_t  q
);

    logic [shbr_pkg::RING_DEPTH-1:0] valid_reg;
    logic [shbr_pkg::CNT_W-1:0]      count_reg [shbr_pkg::RING_DEPTH];
    logic                            rd_valid_reg;
    logic [shbr_pkg::CNT_W-1:0]      rd_count_reg;
    logic [shbr_pkg::TICK_W-1:0]     ram_q;

    shbr_ram #(
        .WIDTH (shbr_pkg::TICK_W),
        .DEPTH (shbr_pkg::RING_DEPTH)
    ) u_tick_ram (
        .clk   (aclk),
        .we    (wr.tick_en),
        .waddr (wr.idx),
        .wdata (wr.tick),
        .re    (rd.en),
        .raddr (rd.idx),
        .rdata (ram_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            rd_count_reg <= '0;
            for (int i = 0; i < shbr_pkg::RING_DEPTH; i++) begin
                count_reg[i] <= '0;
            end
        end else begin
            if (wr.tick_en) begin
                valid_reg[wr.idx] <= 1'b1;
            end
            if (wr.count_en) begin
                count_reg[wr.idx] <= wr.count;
            end
            if (rd.en) begin
                rd_valid_reg <= valid_reg[rd.idx];
                rd_count_reg <= count_reg[rd.idx];
            end
        end
    end

    assign q.tick  = rd_valid_reg ? ram_q : '0;
    assign q.count = rd_count_reg;

endmodule

// ===== hdl/shbr_seq.sv =====
// ----------------------------------------------------------------------------
// shbr_seq: item sequencer of the snapshot history ring
// Records body words, searches slot ticks newest first on an ack, copies
// the hit slot into the baseline region and holds the result register.
// ----------------------------------------------------------------------------
module shbr_seq (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  shbr_pkg::cfg_t                cfg,
    // Input item.
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          in_kind,
    input  logic [shbr_pkg::TICK_W-1:0]   in_tick,
    input  logic [shbr_pkg::DATA_W-1:0]   in_body,
    input  logic                          in_present,
    input  logic                          in_last,
    // Result item.
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          out_status,
    output logic [shbr_pkg::TICK_W-1:0]   out_tick,
    output logic [shbr_pkg::CNT_W-1:0]    out_count,
    // Slot metadata store.
    output shbr_pkg::meta_wr_t            meta_wr,
    output shbr_pkg::meta_rd_t            meta_rd,
    input  shbr_pkg::meta_q_t             meta_q,
    // Body memory.
    output shbr_pkg::body_req_t           body_req,
    input  logic [shbr_pkg::BODY_BITS-1:0] body_rdata
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SEARCH = 4'b0010,
        ST_COPY   = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

    state_t st_reg, st_next;

    logic [shbr_pkg::PTR_W-1:0]   wslot_reg, wslot_next;
    logic [shbr_pkg::RING_W-1:0]  filled_reg, filled_next;
    logic                         open_reg, open_next;
    logic [shbr_pkg::CNT_W-1:0]   ocount_reg, ocount_next;
    logic                         out_valid_reg, out_valid_next;
    logic                         status_reg, status_next;
    logic [shbr_pkg::TICK_W-1:0]  btick_reg, btick_next;
    logic [shbr_pkg::CNT_W-1:0]   bcount_reg, bcount_next;
    logic [shbr_pkg::TICK_W-1:0]  ack_tick_reg, ack_tick_next;
    logic [shbr_pkg::RING_W-1:0]  rem_reg, rem_next;
    logic [shbr_pkg::PTR_W-1:0]   probe_reg, probe_next;
    logic                         cmpv_reg, cmpv_next;
    logic [shbr_pkg::PTR_W-1:0]   cmpidx_reg, cmpidx_next;
    logic [shbr_pkg::BODY_AW-1:0] cp_src_reg, cp_src_next;
    logic [shbr_pkg::CNT_W-1:0]   cp_total_reg, cp_total_next;
    logic [shbr_pkg::CNT_W-1:0]   cp_rd_reg, cp_rd_next;
    logic                         cp_wv_reg, cp_wv_next;
    logic [shbr_pkg::CNT_W-1:0]   cp_wi_reg, cp_wi_next;

    logic [shbr_pkg::PTR_W-1:0] ring_last;
    logic [shbr_pkg::PTR_W-1:0] prev_slot;
    logic                       w_ok;
    logic                       slot_free;
    logic                       accept;

    assign ring_last = shbr_pkg::PTR_W'(cfg.ring - shbr_pkg::RING_W'(1));
    assign prev_slot = (wslot_reg == '0) ? ring_last
                                         : wslot_reg - shbr_pkg::PTR_W'(1);
    assign w_ok      = 32'(wslot_reg) < 32'(cfg.ring);
    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (st_reg == ST_IDLE) && w_ok && slot_free;
    assign accept    = in_valid && in_ready;

    always_comb begin
        logic [shbr_pkg::RING_W-1:0] f;
        logic [shbr_pkg::CNT_W-1:0]  oc;
        logic [shbr_pkg::CNT_W-1:0]  c;
        logic                        issue;

        st_next        = st_reg;
        wslot_next     = wslot_reg;
        filled_next    = filled_reg;
        open_next      = open_reg;
        ocount_next    = ocount_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        btick_next     = btick_reg;
        bcount_next    = bcount_reg;
        ack_tick_next  = ack_tick_reg;
        rem_next       = rem_reg;
        probe_next     = probe_reg;
        cmpv_next      = cmpv_reg;
        cmpidx_next    = cmpidx_reg;
        cp_src_next    = cp_src_reg;
        cp_total_next  = cp_total_reg;
        cp_rd_next     = cp_rd_reg;
        cp_wv_next     = cp_wv_reg;
        cp_wi_next     = cp_wi_reg;
        meta_wr        = '0;
        meta_rd        = '0;
        body_req       = '0;
        f              = filled_reg;
        oc             = ocount_reg;
        c              = '0;
        issue          = 1'b0;

        unique case (st_reg)
            ST_IDLE: begin
                // After a ring size change, fold the pointer back into range.
                if (!w_ok) begin
                    wslot_next = shbr_pkg::PTR_W'(32'(wslot_reg) - 32'(cfg.ring));
                end
                if (accept && in_kind == shbr_pkg::KIND_ACK) begin
                    ack_tick_next = in_tick;
                    rem_next      = (filled_reg < cfg.ring) ? filled_reg : cfg.ring;
                    probe_next    = prev_slot;
                    cmpv_next     = 1'b0;
                    st_next       = ST_SEARCH;
                end else if (accept) begin
                    if (!open_reg) begin
                        // The slot being overwritten leaves the filled set now.
                        if (f >= cfg.ring) begin
                            f = cfg.ring - shbr_pkg::RING_W'(1);
                        end
                        meta_wr.tick_en = 1'b1;
                        meta_wr.tick    = in_tick;
                        oc              = '0;
                    end
                    meta_wr.idx = wslot_reg;
                    if (in_present && oc < cfg.limit) begin
                        body_req.we    = 1'b1;
                        body_req.waddr = shbr_pkg::BODY_AW'(
                            32'(wslot_reg) * shbr_pkg::SLOT_BODIES + 32'(oc));
                        body_req.wdata = in_body[shbr_pkg::BODY_BITS-1:0];
                        oc             = oc + shbr_pkg::CNT_W'(1);
                    end
                    if (in_last) begin
                        meta_wr.count_en = 1'b1;
                        meta_wr.count    = oc;
                        wslot_next = (32'(wslot_reg) + 1 >= 32'(cfg.ring))
                                     ? '0 : wslot_reg + shbr_pkg::PTR_W'(1);
                        if (f > cfg.ring) begin
                            f = cfg.ring;
                        end
                        if (f < cfg.ring) begin
                            f = f + shbr_pkg::RING_W'(1);
                        end
                        open_next   = 1'b0;
                        ocount_next = '0;
                    end else begin
                        open_next   = 1'b1;
                        ocount_next = oc;
                    end
                    filled_next    = f;
                    status_next    = shbr_pkg::STATUS_OK;
                    out_valid_next = 1'b1;
                end
            end

            ST_SEARCH: begin
                // Reads issue one per cycle; each compare sees the previous read.
                issue       = (rem_reg != '0);
                meta_rd.en  = issue;
                meta_rd.idx = probe_reg;
                if (issue) begin
                    rem_next   = rem_reg - shbr_pkg::RING_W'(1);
                    probe_next = (probe_reg == '0) ? ring_last
                                                   : probe_reg - shbr_pkg::PTR_W'(1);
                end
                cmpv_next   = issue;
                cmpidx_next = probe_reg;
                if (cmpv_reg && meta_q.tick == ack_tick_reg) begin
                    c = (32'(meta_q.count) > shbr_pkg::SLOT_BODIES)
                        ? shbr_pkg::CNT_W'(shbr_pkg::SLOT_BODIES) : meta_q.count;
                    btick_next    = ack_tick_reg;
                    bcount_next   = c;
                    cp_src_next   = shbr_pkg::BODY_AW'(
                        32'(cmpidx_reg) * shbr_pkg::SLOT_BODIES);
                    cp_total_next = c;
                    cp_rd_next    = '0;
                    cp_wv_next    = 1'b0;
                    status_next   = shbr_pkg::STATUS_OK;
                    st_next       = ST_COPY;
                end else if (!cmpv_reg && !issue) begin
                    status_next = shbr_pkg::STATUS_EXPIRED;
                    st_next     = ST_DONE;
                end
            end

            ST_COPY: begin
                // Read word k of the slot while word k-1 lands in the baseline.
                issue          = (cp_rd_reg < cp_total_reg);
                body_req.re    = issue;
                body_req.raddr = cp_src_reg + shbr_pkg::BODY_AW'(cp_rd_reg);
                if (issue) begin
                    cp_rd_next = cp_rd_reg + shbr_pkg::CNT_W'(1);
                end
                cp_wv_next = issue;
                cp_wi_next = cp_rd_reg;
                if (cp_wv_reg) begin
                    body_req.we    = 1'b1;
                    body_req.waddr = shbr_pkg::BODY_AW'(
                        shbr_pkg::BASE_OFF + 32'(cp_wi_reg));
                    body_req.wdata = body_rdata;
                end
                if (!issue && !cp_wv_reg) begin
                    st_next = ST_DONE;
                end
            end

            ST_DONE: begin
                if (slot_free) begin
                    out_valid_next = 1'b1;
                    st_next        = ST_IDLE;
                end
            end

            default: begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= ST_IDLE;
            wslot_reg     <= '0;
            filled_reg    <= '0;
            open_reg      <= 1'b0;
            ocount_reg    <= '0;
            out_valid_reg <= 1'b0;
            btick_reg     <= '0;
            bcount_reg    <= '0;
            rem_reg       <= '0;
            cmpv_reg      <= 1'b0;
            cp_total_reg  <= '0;
            cp_rd_reg     <= '0;
            cp_wv_reg     <= 1'b0;
        end else begin
            st_reg        <= st_next;
            wslot_reg     <= wslot_next;
            filled_reg    <= filled_next;
            open_reg      <= open_next;
            ocount_reg    <= ocount_next;
            out_valid_reg <= out_valid_next;
            btick_reg     <= btick_next;
            bcount_reg    <= bcount_next;
            rem_reg       <= rem_next;
            cmpv_reg      <= cmpv_next;
            cp_total_reg  <= cp_total_next;
            cp_rd_reg     <= cp_rd_next;
            cp_wv_reg     <= cp_wv_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg   <= status_next;
        ack_tick_reg <= ack_tick_next;
        probe_reg    <= probe_next;
        cmpidx_reg   <= cmpidx_next;
        cp_src_reg   <= cp_src_next;
        cp_wi_reg    <= cp_wi_next;
    end

    // The baseline only changes while no result is pending, so it drives
    // the result payload directly.
    assign out_valid  = out_valid_reg;
    assign out_status = status_reg;
    assign out_tick   = btick_reg;
    assign out_count  = bcount_reg;

`ifndef SYNTHESIS
    a_wslot_in_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> (32'(wslot_reg) < 32'(cfg.ring)))
        else $error("write pointer outside the ring at item accept");

    a_filled_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(filled_reg) <= shbr_pkg::RING_DEPTH)
        else $error("filled slot count above ring depth");

    a_no_body_write_in_search: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_SEARCH) |-> !body_req.we)
        else $error("body memory written during tick search");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |->
            $past(st_reg == ST_DONE || (accept && in_kind == shbr_pkg::KIND_RECORD)))
        else $error("result raised outside record accept or ack completion");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg != ST_IDLE) |-> !in_ready)
        else $error("input ready while an ack is in progress");
`endif

endmodule

// ===== tb/sv/snapshot_history_baseline_ring_test.sv =====
// ----------------------------------------------------------------------------
// snapshot_history_baseline_ring_test: self-checking bench for the snapshot ring
// Streams record and acknowledge beats into the ring, predicts every result
// beat with a behavioral copy of the ring and baseline state, and compares
// status, baseline tick and baseline count beat by beat. Directed cases come
// first, then constrained-random traffic over several register settings.
// ----------------------------------------------------------------------------
module snapshot_history_baseline_ring_test;

    // Register indexes past the end of the list. Writes to them must be ignored.
    localparam logic [shbr_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
    localparam logic [shbr_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 2'd3;

    // A long ack copies up to 64 words after a 16-slot search, so the quiet
    // period at the end is comfortably beyond the slowest beat.
    localparam int SETTLE_CYCLES  = 100;
    localparam int CFG_SETTLE     = 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 250;
    localparam int HISTORY_MAX    = 48;

    // One input beat, unpacked into its fields.
    typedef struct packed {
        logic                        kind;
        logic [shbr_pkg::TICK_W-1:0] tick;
        logic [shbr_pkg::DATA_W-1:0] body;
        logic                        present;
        logic                        is_last;
    } snap_beat_t;

    // One result beat, unpacked into its fields.
    typedef struct packed {
        logic                        status;
        logic [shbr_pkg::TICK_W-1:0] tick;
        logic [shbr_pkg::CNT_W-1:0]  count;
    } baseline_t;

    // Result-side stall patterns.
    typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_PATTERN, RX_SPARSE} rx_mode_t;

    // ------------------------------------------------------------------------
    // Clock, reset and block ports. Every input is known from time zero.
    // ------------------------------------------------------------------------
    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            cfg_we    = 1'b0;
    logic [shbr_pkg::CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [shbr_pkg::CFG_DAT_W-1:0]  cfg_wdata = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [shbr_pkg::S_TDATA_W-1:0]  s_tdata   = '0;  // tick, body_data
    logic [shbr_pkg::S_TUSER_W-1:0]  s_tuser   = '0;  // kind, body_present
    logic                            s_tlast   = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [shbr_pkg::M_TDATA_W-1:0]  m_tdata;         // base_tick, base_count
    logic [shbr_pkg::M_TUSER_W-1:0]  m_tuser;         // status

    always #5 aclk = ~aclk;

    snapshot_history_baseline_ring dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // ------------------------------------------------------------------------
    // Behavioral copy of the ring. Body words never reach a result beat, so
    // only the tick and count of each slot and of the baseline are tracked.
    // ------------------------------------------------------------------------
    logic [shbr_pkg::TICK_W-1:0] ring_tick  [shbr_pkg::RING_DEPTH];
    logic [shbr_pkg::CNT_W-1:0]  slot_words [shbr_pkg::RING_DEPTH];
    logic [shbr_pkg::TICK_W-1:0] base_tick_m;
    logic [shbr_pkg::CNT_W-1:0]  base_count_m;
    int unsigned                 wr_ptr;
    int unsigned                 filled_cnt;
    int unsigned                 open_words;
    bit                          rec_open;
    logic [shbr_pkg::RING_W-1:0] cfg_ring;
    logic [shbr_pkg::CNT_W-1:0]  cfg_limit;

    baseline_t                   baseline_q [$];
    logic [shbr_pkg::TICK_W-1:0] recorded_ticks [$];

    // Bookkeeping for the checker, the watchdog and the closing summary.
    int unsigned mismatches   = 0;
    int unsigned results_seen = 0;
    int unsigned items_sent   = 0;
    int unsigned record_beats = 0;
    int unsigned acks_hit     = 0;
    int unsigned acks_expired = 0;
    int unsigned reg_writes   = 0;
    int unsigned idle_cycles  = 0;

    // Sender burst state and the receiver's stall controls.
    int unsigned burst_left = 0;
    int unsigned hold_req   = 0;
    int unsigned hold_left  = 0;
    int unsigned mode_left  = 0;
    int unsigned rx_phase   = 0;
    rx_mode_t    rx_mode    = RX_ALWAYS;

    function automatic void reset_ring_model();
        for (int i = 0; i < shbr_pkg::RING_DEPTH; i++) begin
            ring_tick[i]  = '0;
            slot_words[i] = '0;
        end
        base_tick_m  = '0;
        base_count_m = '0;
        wr_ptr       = 0;
        filled_cnt   = 0;
        open_words   = 0;
        rec_open     = 1'b0;
        cfg_ring     = shbr_pkg::RING_W'(shbr_pkg::RING_DEPTH);
        cfg_limit    = shbr_pkg::CNT_W'(shbr_pkg::SLOT_BODIES);
    endfunction

    // Applies one beat to the ring copy and returns the result it must cause.
    function automatic baseline_t predict_baseline(input snap_beat_t beat);
        int unsigned ring;
        int unsigned lim;
        int unsigned w;
        int unsigned n;
        int unsigned idx;
        bit          hit;
        baseline_t   res;
        // Out-of-range register values act as the nearest legal value.
        ring = (cfg_ring < 1) ? 1
             : (cfg_ring > shbr_pkg::RING_DEPTH) ? shbr_pkg::RING_DEPTH : cfg_ring;
        lim  = (cfg_limit > shbr_pkg::SLOT_BODIES) ? shbr_pkg::SLOT_BODIES : cfg_limit;
        // A shrunken ring folds the write pointer back into range.
        w      = wr_ptr % ring;
        wr_ptr = w;
        res.status = shbr_pkg::STATUS_OK;
        if (beat.kind == shbr_pkg::KIND_ACK) begin
            // Newest closed slot first, walking back through the filled set.
            n   = (filled_cnt < ring) ? filled_cnt : ring;
            hit = 1'b0;
            for (int i = 0; i < n && !hit; i++) begin
                idx = (w + ring - 1 - i) % ring;
                if (ring_tick[idx] == beat.tick) begin
                    hit          = 1'b1;
                    base_tick_m  = beat.tick;
                    base_count_m = slot_words[idx];
                    if (base_count_m > shbr_pkg::SLOT_BODIES)
                        base_count_m = shbr_pkg::CNT_W'(shbr_pkg::SLOT_BODIES);
                end
            end
            res.status = hit ? shbr_pkg::STATUS_OK : shbr_pkg::STATUS_EXPIRED;
        end else begin
            if (!rec_open) begin
                // The slot about to be overwritten drops out of the search set.
                if (filled_cnt >= ring)
                    filled_cnt = ring - 1;
                ring_tick[w] = beat.tick;
                open_words   = 0;
                rec_open     = 1'b1;
            end
            if (beat.present && open_words < lim)
                open_words++;
            if (beat.is_last) begin
                slot_words[w] = shbr_pkg::CNT_W'(open_words);
                wr_ptr        = (w + 1 >= ring) ? 0 : w + 1;
                if (filled_cnt > ring)
                    filled_cnt = ring;
                if (filled_cnt < ring)
                    filled_cnt++;
                rec_open   = 1'b0;
                open_words = 0;
            end
        end
        res.tick  = base_tick_m;
        res.count = base_count_m;
        return res;
    endfunction

    task automatic note_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("Mismatch in result %0d, %s: expected %h, got %h",
                     results_seen, field, want, got);
    endtask

    // ------------------------------------------------------------------------
    // Monitor. Samples both channels and the register port at each rising
    // edge. The result side is handled before the input side, so a beat that
    // enters in the same cycle as an older result leaves is ordered correctly.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        baseline_t  want;
        baseline_t  got;
        snap_beat_t beat;
        if (aresetn) begin
            idle_cycles++;
            if (m_tvalid && m_tready) begin
                idle_cycles  = 0;
                got.status = m_tuser[0];
                got.tick   = m_tdata[shbr_pkg::TICK_W-1:0];
                got.count  = m_tdata[shbr_pkg::TICK_W +: shbr_pkg::CNT_W];
                if (baseline_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Result beat %0d arrived with nothing predicted: %h %h %h",
                                 results_seen, got.status, got.tick, got.count);
                end else begin
                    want = baseline_q.pop_front();
                    if (got.status !== want.status)
                        note_mismatch("status", 64'(want.status), 64'(got.status));
                    if (got.tick !== want.tick)
                        note_mismatch("base_tick", want.tick, got.tick);
                    if (got.count !== want.count)
                        note_mismatch("base_count", 64'(want.count), 64'(got.count));
                end
                results_seen++;
            end
            if (cfg_we) begin
                case (cfg_idx)
                    shbr_pkg::CFG_RING_SIZE:  cfg_ring  = cfg_wdata[shbr_pkg::RING_W-1:0];
                    shbr_pkg::CFG_SLOT_LIMIT: cfg_limit = cfg_wdata[shbr_pkg::CNT_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                idle_cycles  = 0;
                beat.tick    = s_tdata[shbr_pkg::TICK_W-1:0];
                beat.body    = s_tdata[shbr_pkg::TICK_W +: shbr_pkg::DATA_W];
                beat.kind    = s_tuser[0];
                beat.present = s_tuser[1];
                beat.is_last = s_tlast;
                want = predict_baseline(beat);
                baseline_q.push_back(want);
                if (beat.kind == shbr_pkg::KIND_ACK) begin
                    if (want.status == shbr_pkg::STATUS_OK)
                        acks_hit++;
                    else
                        acks_expired++;
                end else begin
                    record_beats++;
                end
            end
        end
    end

    // Watchdog: the run ends if nothing moves on either channel for too long.
    initial begin
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge aclk);
        $display("Watchdog expired after %0d quiet cycles, %0d results outstanding",
                 idle_cycles, baseline_q.size());
        $display("FAILED: results differ");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver. Switches between random stall patterns; a long hold
    // requested by a test overrides the pattern and is counted down here.
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (mode_left == 0) begin
            rx_mode   = rx_mode_t'($urandom_range(0, 3));
            mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        rx_phase++;
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS:  m_tready <= 1'b1;
                RX_COIN:    m_tready <= 1'($urandom_range(0, 1));
                RX_PATTERN: m_tready <= (rx_phase % 7) > 2;
                default:    m_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Sender helpers. Every task is entered and left just after a falling
    // edge. tvalid stays high between back-to-back beats; any task that lets
    // time pass without sending lowers it first.
    // ------------------------------------------------------------------------
    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_beat(input snap_beat_t beat);
        int unsigned gap;
        if (burst_left == 0) begin
            // Either a long unbroken burst or a short one after a gap.
            if ($urandom_range(0, 3) == 0) begin
                burst_left = $urandom_range(30, 80);
                gap        = 0;
            end else begin
                burst_left = $urandom_range(1, 12);
                gap        = $urandom_range(0, 8);
            end
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= shbr_pkg::S_TDATA_W'({beat.body, beat.tick});
        s_tuser  <= {beat.present, beat.kind};
        s_tlast  <= beat.is_last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_rec(input logic [shbr_pkg::TICK_W-1:0] tick,
                            input logic [shbr_pkg::DATA_W-1:0] body,
                            input logic present, input logic is_last);
        snap_beat_t beat;
        beat.kind    = shbr_pkg::KIND_RECORD;
        beat.tick    = tick;
        beat.body    = body;
        beat.present = present;
        beat.is_last = is_last;
        send_beat(beat);
    endtask

    // The flag bits of an ack are don't-care; they are randomized.
    task automatic send_ack(input logic [shbr_pkg::TICK_W-1:0] tick);
        snap_beat_t beat;
        beat.kind    = shbr_pkg::KIND_ACK;
        beat.tick    = tick;
        beat.body    = rand64();
        beat.present = 1'($urandom_range(0, 1));
        beat.is_last = 1'($urandom_range(0, 1));
        send_beat(beat);
    endtask

    // A whole snapshot: the first beat carries the tick, later beats carry
    // noise there. Zero words gives one beat with no body and last set.
    task automatic send_snapshot(input logic [shbr_pkg::TICK_W-1:0] tick,
                                 input int unsigned words, input bit gappy);
        logic present;
        if (words == 0) begin
            send_rec(tick, rand64(), 1'b0, 1'b1);
        end else begin
            for (int unsigned i = 0; i < words; i++) begin
                present = gappy ? ($urandom_range(0, 5) != 0) : 1'b1;
                send_rec((i == 0) ? tick : rand64(), rand64(), present, i == words - 1);
            end
        end
        recorded_ticks.push_back(tick);
        if (recorded_ticks.size() > HISTORY_MAX)
            void'(recorded_ticks.pop_front());
    endtask

    function automatic logic [shbr_pkg::TICK_W-1:0] pick_recorded();
        if (recorded_ticks.size() == 0)
            return rand64();
        return recorded_ticks[$urandom_range(0, recorded_ticks.size() - 1)];
    endfunction

    task automatic pause_until_drained();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (baseline_q.size() != 0)
            @(negedge aclk);
    endtask

    // Registers change only with nothing in flight, then a short pause so
    // any internal cleanup after the last result has finished.
    task automatic write_reg(input logic [shbr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [shbr_pkg::CFG_DAT_W-1:0] value);
        pause_until_drained();
        repeat (CFG_SETTLE) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        @(negedge aclk);
        reg_writes++;
    endtask

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Field extremes, empty snapshots, ignored later ticks, an ack while a
    // record is open and a tick recorded twice (newest copy wins).
    task automatic test_directed_basics();
        logic [shbr_pkg::TICK_W-1:0] t_open;
        logic [shbr_pkg::TICK_W-1:0] t_dup;
        logic [shbr_pkg::TICK_W-1:0] t_skip;
        t_open = rand64();
        t_dup  = rand64();
        t_skip = rand64();
        send_ack('0);                          // nothing recorded yet
        send_rec('1, '1, 1'b1, 1'b0);
        send_rec(rand64(), '0, 1'b1, 1'b0);
        send_rec(rand64(), '1, 1'b1, 1'b1);
        send_rec('0, rand64(), 1'b0, 1'b1);    // empty snapshot at tick zero
        send_ack('1);
        send_ack('0);
        send_rec(t_skip, '0, 1'b1, 1'b0);
        send_rec(rand64(), rand64(), 1'b0, 1'b0);
        send_rec(~t_skip, rand64(), 1'b1, 1'b1);
        send_ack(t_skip);
        send_ack(~t_skip);                     // a later beat's tick is not kept
        send_rec(t_open, rand64(), 1'b1, 1'b0);
        send_rec(rand64(), rand64(), 1'b1, 1'b0);
        send_ack('1);                          // hits a closed slot mid-record
        send_ack(t_open);                      // the open slot is not searched
        send_rec(rand64(), rand64(), 1'b1, 1'b1);
        send_ack(t_open);
        send_snapshot(t_dup, 1, 1'b0);
        send_snapshot(t_dup, 2, 1'b0);
        send_ack(t_dup);
        send_ack(rand64());
        pause_until_drained();
    endtask

    // Slot limit at zero, small, clamped from above, and lowered mid-record.
    task automatic test_slot_limit();
        logic [shbr_pkg::TICK_W-1:0] t_snap;
        t_snap = rand64();
        write_reg(shbr_pkg::CFG_SLOT_LIMIT, 7'd0);
        send_snapshot(t_snap, 3, 1'b0);
        send_ack(t_snap);
        t_snap = rand64();
        write_reg(shbr_pkg::CFG_SLOT_LIMIT, 7'd3);
        send_snapshot(t_snap, 5, 1'b0);
        send_ack(t_snap);
        t_snap = rand64();
        write_reg(shbr_pkg::CFG_SLOT_LIMIT, 7'h7F);
        send_snapshot(t_snap, shbr_pkg::SLOT_BODIES + 2, 1'b0);
        send_ack(t_snap);
        // Five words kept, then the limit drops under them: they stay.
        t_snap = rand64();
        write_reg(shbr_pkg::CFG_SLOT_LIMIT, 7'd64);
        for (int i = 0; i < 5; i++)
            send_rec((i == 0) ? t_snap : rand64(), rand64(), 1'b1, 1'b0);
        write_reg(shbr_pkg::CFG_SLOT_LIMIT, 7'd2);
        send_rec(rand64(), rand64(), 1'b1, 1'b0);
        send_rec(rand64(), rand64(), 1'b1, 1'b1);
        send_ack(t_snap);
        write_reg(CFG_IDX_SPARE_A, '1);
        write_reg(CFG_IDX_SPARE_B, 7'h01);
        write_reg(shbr_pkg::CFG_SLOT_LIMIT, 7'd64);
        send_ack(t_snap);
        pause_until_drained();
    endtask

    // Wrap-around at full size, shrinking with a full ring, growing back
    // over stale slots, and the single-slot ring reached both ways.
    task automatic test_ring_size();
        logic [shbr_pkg::TICK_W-1:0] fill_ticks [0:16];
        logic [shbr_pkg::TICK_W-1:0] t_a;
        logic [shbr_pkg::TICK_W-1:0] t_b;
        logic [shbr_pkg::TICK_W-1:0] t_c;
        t_a = rand64();
        t_b = rand64();
        t_c = rand64();
        write_reg(shbr_pkg::CFG_RING_SIZE, 7'h7F);   // masks to 31, acts as full depth
        for (int i = 0; i <= 16; i++) begin
            fill_ticks[i] = rand64();
            send_snapshot(fill_ticks[i], i % 3, 1'b0);
        end
        send_ack(fill_ticks[0]);               // overwritten by the wrap
        send_ack(fill_ticks[1]);
        send_ack(fill_ticks[16]);
        write_reg(shbr_pkg::CFG_RING_SIZE, 7'd5);
        send_ack(fill_ticks[16]);
        send_ack(fill_ticks[12]);
        send_ack(fill_ticks[11]);
        send_snapshot(rand64(), 1, 1'b0);
        write_reg(shbr_pkg::CFG_RING_SIZE, 7'd17);
        send_ack(fill_ticks[5]);
        send_ack(fill_ticks[12]);
        write_reg(shbr_pkg::CFG_RING_SIZE, 7'd1);
        send_snapshot(t_a, 2, 1'b0);
        send_snapshot(t_b, 1, 1'b0);
        send_ack(t_a);
        send_ack(t_b);
        // With one slot, an open record empties the search set.
        send_rec(t_c, rand64(), 1'b1, 1'b0);
        send_ack(t_b);
        send_rec(rand64(), rand64(), 1'b1, 1'b1);
        send_ack(t_c);
        write_reg(shbr_pkg::CFG_RING_SIZE, 7'd0);    // acts as one slot
        send_snapshot(t_a, 1, 1'b0);
        send_ack(t_a);
        send_ack(t_c);
        write_reg(shbr_pkg::CFG_RING_SIZE, 7'd16);
    endtask

    // The receiver stops for a long stretch while short snapshots keep
    // coming, so the block backs up and holds its input off.
    task automatic test_receiver_hold();
        hold_req = LONG_HOLD;
        for (int i = 0; i < 24; i++)
            send_snapshot(rand64(), $urandom_range(0, 2), 1'b0);
        for (int i = 0; i < 6; i++)
            send_ack(pick_recorded());
        pause_until_drained();
    endtask

    // Mostly well-formed snapshots with random content and acks aimed at
    // recent and older ticks, mixed with raw noise beats, over several
    // register settings. The first two phases pin the extremes.
    task automatic test_random_traffic();
        int unsigned target;
        int unsigned phase_end;
        int unsigned phase_no;
        int unsigned sel;
        int unsigned words;
        logic [shbr_pkg::CFG_DAT_W-1:0] ring_val;
        logic [shbr_pkg::CFG_DAT_W-1:0] limit_val;
        snap_beat_t noise;
        target   = items_sent + 260;
        phase_no = 0;
        while (items_sent < target) begin
            // The ring size only changes between snapshots.
            if (rec_open)
                send_rec(rand64(), rand64(), 1'($urandom_range(0, 1)), 1'b1);
            case (phase_no)
                0: begin
                    ring_val  = 7'd1;
                    limit_val = 7'd0;
                end
                1: begin
                    ring_val  = 7'd16;
                    limit_val = 7'd64;
                end
                default: begin
                    case ($urandom_range(0, 5))
                        0:       ring_val = 7'd0;
                        1:       ring_val = 7'($urandom_range(17, 127));
                        2:       ring_val = 7'($urandom_range(1, 4));
                        default: ring_val = 7'($urandom_range(1, 16));
                    endcase
                    case ($urandom_range(0, 4))
                        0:       limit_val = 7'($urandom_range(65, 127));
                        1:       limit_val = 7'($urandom_range(0, 4));
                        default: limit_val = 7'($urandom_range(0, 64));
                    endcase
                end
            endcase
            write_reg(shbr_pkg::CFG_RING_SIZE, ring_val);
            write_reg(shbr_pkg::CFG_SLOT_LIMIT, limit_val);
            phase_no++;
            phase_end = items_sent + $urandom_range(40, 80);
            while (items_sent < phase_end && items_sent < target) begin
                sel = $urandom_range(0, 19);
                if (sel < 11) begin
                    if ($urandom_range(0, 19) == 0)
                        words = $urandom_range(40, 70);
                    else if ($urandom_range(0, 5) == 0)
                        words = $urandom_range(6, 16);
                    else
                        words = $urandom_range(0, 5);
                    send_snapshot(($urandom_range(0, 7) == 0) ? pick_recorded() : rand64(),
                                  words, $urandom_range(0, 3) == 0);
                end else if (sel < 17) begin
                    send_ack(pick_recorded());
                end else if (sel < 18) begin
                    send_ack(rand64());
                end else begin
                    noise.kind    = 1'($urandom_range(0, 1));
                    noise.tick    = $urandom_range(0, 1) ? pick_recorded() : rand64();
                    noise.body    = rand64();
                    noise.present = 1'($urandom_range(0, 1));
                    noise.is_last = 1'($urandom_range(0, 1));
                    send_beat(noise);
                end
            end
            pause_until_drained();
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence: hold reset, run the tests in turn, then wait for the last
    // result and a quiet period before the verdict.
    // ------------------------------------------------------------------------
    initial begin
        reset_ring_model();
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed_basics();
        test_slot_limit();
        test_ring_size();
        test_receiver_hold();
        test_random_traffic();
        pause_until_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Covered %0d input beats: %0d record beats and %0d acks (%0d hit, %0d expired).",
                 items_sent, record_beats, acks_hit + acks_expired, acks_hit, acks_expired);
        $display("Register writes: %0d, ring sizes 0 to 127 and slot limits 0 to 127 exercised.",
                 reg_writes);
        if (mismatches == 0 && baseline_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatches, %0d results still outstanding",
                     mismatches, baseline_q.size());
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/shbr_pkg.sv
hdl/shbr_ram.sv
hdl/shbr_meta.sv
hdl/shbr_seq.sv
hdl/snapshot_history_baseline_ring.sv
tb/sv/snapshot_history_baseline_ring_test.sv
